// ----- rtl/core/m3i_pkg.sv -----
`timescale 1ns / 1ps
// m3i_pkg: shared types, widths and constant tables for the 3x3 matrix inverse
// depends on nothing; used by every module of the block

package m3i_pkg;

  localparam int ELEM_W = 32;
  localparam int N_EL   = 9;
  localparam int PROD_W = 64;
  localparam int COF_W  = 64;
  localparam int PLO_W  = 65;
  localparam int TERM_W = 96;
  localparam int DET_W  = 98;
  localparam int MAG_W  = 96;
  localparam int DEN_W  = 97;
  localparam int NUM_W  = 97;
  localparam int QUO_W  = 33;
  localparam int DIV_NS = QUO_W + 1;

  localparam logic [ELEM_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;
  localparam logic [QUO_W-1:0]  LIM_POS = 33'h0_7fff_ffff;
  localparam logic [QUO_W-1:0]  LIM_NEG = 33'h0_8000_0000;

  localparam logic [ELEM_W-1:0] IDENT [N_EL] = '{
    Q_ONE, 32'h0, 32'h0, 32'h0, Q_ONE, 32'h0, 32'h0, 32'h0, Q_ONE};

  // cofactor k = a[P]*a[S] - a[Q]*a[R]
  localparam logic [3:0] MIN_P [N_EL] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] MIN_S [N_EL] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] MIN_Q [N_EL] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] MIN_R [N_EL] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_el_t;

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02;
    elem_t a10; elem_t a11; elem_t a12;
    elem_t a20; elem_t a21; elem_t a22;
  } in_t;

  typedef struct packed {
    elem_t inv00; elem_t inv01; elem_t inv02;
    elem_t inv10; elem_t inv11; elem_t inv12;
    elem_t inv20; elem_t inv21; elem_t inv22;
    logic  singular;
  } out_t;

  typedef struct packed {
    logic [2:0][ELEM_W-1:0]  row0;
    logic [N_EL-1:0][COF_W-1:0] cof;
  } cof_beat_t;

  typedef struct packed {
    logic [N_EL-1:0][NUM_W-1:0] num;
    logic [N_EL-1:0]            neg;
    logic [DEN_W-1:0]           d2;
    logic                       singular;
  } div_beat_t;

  typedef struct packed {
    logic [N_EL-1:0][QUO_W-1:0] quo;
    logic [N_EL-1:0]            ovf;
    logic [N_EL-1:0]            neg;
    logic                       singular;
  } quo_beat_t;

endpackage

// ----- rtl/core/m3i_cof.sv -----
`timescale 1ns / 1ps
// m3i_cof: input register, 2x2 minor products and the nine cofactors
// depends on m3i_pkg

module m3i_cof (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::in_t       in_data,
  output logic               out_valid,
  output m3i_pkg::cof_beat_t out_data
);

  m3i_pkg::elem_t a_in [m3i_pkg::N_EL];
  m3i_pkg::elem_t a_r  [m3i_pkg::N_EL];
  logic signed [m3i_pkg::PROD_W-1:0] pa_r [m3i_pkg::N_EL];
  logic signed [m3i_pkg::PROD_W-1:0] pb_r [m3i_pkg::N_EL];
  m3i_pkg::elem_t row2_r [3];
  m3i_pkg::elem_t row3_r [3];
  m3i_pkg::cof_el_t cof_r [m3i_pkg::N_EL];
  logic v1_r, v2_r, v3_r;

  assign a_in[0] = in_data.a00;
  assign a_in[1] = in_data.a01;
  assign a_in[2] = in_data.a02;
  assign a_in[3] = in_data.a10;
  assign a_in[4] = in_data.a11;
  assign a_in[5] = in_data.a12;
  assign a_in[6] = in_data.a20;
  assign a_in[7] = in_data.a21;
  assign a_in[8] = in_data.a22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::N_EL; k++) begin
        a_r[k]   <= a_in[k];
        pa_r[k]  <= a_r[m3i_pkg::MIN_P[k]] * a_r[m3i_pkg::MIN_S[k]];
        pb_r[k]  <= a_r[m3i_pkg::MIN_Q[k]] * a_r[m3i_pkg::MIN_R[k]];
        cof_r[k] <= pa_r[k] - pb_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        row2_r[j] <= a_r[j];
        row3_r[j] <= row2_r[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      out_data.row0[j] = row3_r[j];
    end
    for (int k = 0; k < m3i_pkg::N_EL; k++) begin
      out_data.cof[k] = cof_r[k];
    end
  end

  assign out_valid = v3_r;

endmodule

// ----- rtl/core/m3i_det.sv -----
`timescale 1ns / 1ps
// m3i_det: determinant by first-row expansion, split 32x64 products,
// then divisor and rounded numerators for the divider; depends on m3i_pkg

module m3i_det (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::cof_beat_t in_data,
  output logic               out_valid,
  output m3i_pkg::div_beat_t out_data
);

  logic signed [m3i_pkg::PLO_W-1:0]  plo_r  [3];
  logic signed [m3i_pkg::PROD_W-1:0] phi_r  [3];
  logic signed [m3i_pkg::TERM_W-1:0] term_r [3];
  logic signed [m3i_pkg::DET_W-1:0]  det_r;
  logic [m3i_pkg::N_EL-1:0][m3i_pkg::COF_W-1:0] cof4_r, cof5_r, cof6_r;
  logic v4_r, v5_r, v6_r, v7_r;

  logic                          dneg;
  logic [m3i_pkg::DET_W-1:0]     det_neg;
  logic [m3i_pkg::MAG_W-1:0]     dmag;
  logic [m3i_pkg::COF_W-1:0]     cmag [m3i_pkg::N_EL];
  m3i_pkg::div_beat_t            beat_nxt;
  m3i_pkg::div_beat_t            beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j]  <= $signed(in_data.row0[j]) * $signed({1'b0, in_data.cof[j][31:0]});
        phi_r[j]  <= $signed(in_data.row0[j]) * $signed(in_data.cof[j][63:32]);
        term_r[j] <= $signed({phi_r[j], 32'b0})
                   + $signed({{(m3i_pkg::TERM_W-m3i_pkg::PLO_W){plo_r[j][m3i_pkg::PLO_W-1]}},
                              plo_r[j]});
      end
      det_r  <= $signed({{2{term_r[0][m3i_pkg::TERM_W-1]}}, term_r[0]})
              + $signed({{2{term_r[1][m3i_pkg::TERM_W-1]}}, term_r[1]})
              + $signed({{2{term_r[2][m3i_pkg::TERM_W-1]}}, term_r[2]});
      cof4_r <= in_data.cof;
      cof5_r <= cof4_r;
      cof6_r <= cof5_r;
      beat_r <= beat_nxt;
    end
  end

  always_comb begin
    dneg    = det_r[m3i_pkg::DET_W-1];
    det_neg = -det_r;
    dmag    = dneg ? det_neg[m3i_pkg::MAG_W-1:0] : det_r[m3i_pkg::MAG_W-1:0];
    beat_nxt.d2       = {dmag, 1'b0};
    beat_nxt.singular = (det_r == '0);
    // output (i, j) divides cofactor (j, i)
    for (int o = 0; o < m3i_pkg::N_EL; o++) begin
      cmag[o] = cof6_r[(o % 3) * 3 + o / 3][m3i_pkg::COF_W-1]
              ? -cof6_r[(o % 3) * 3 + o / 3] : cof6_r[(o % 3) * 3 + o / 3];
      beat_nxt.num[o] = {cmag[o], {m3i_pkg::QUO_W{1'b0}}} + {1'b0, dmag};
      beat_nxt.neg[o] = cof6_r[(o % 3) * 3 + o / 3][m3i_pkg::COF_W-1] ^ dneg;
    end
  end

  assign out_valid = v7_r;
  assign out_data  = beat_r;

endmodule

// ----- rtl/core/m3i_div.sv -----
`timescale 1ns / 1ps
// m3i_div: nine-lane pipelined restoring divider, one quotient bit per stage,
// with an up-front overflow check; depends on m3i_pkg

module m3i_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::div_beat_t in_data,
  output logic               out_valid,
  output m3i_pkg::quo_beat_t out_data
);

  logic [m3i_pkg::DEN_W-1:0] rem_r [m3i_pkg::DIV_NS][m3i_pkg::N_EL];
  logic [m3i_pkg::QUO_W-1:0] nlo_r [m3i_pkg::DIV_NS][m3i_pkg::N_EL];
  logic [m3i_pkg::QUO_W-1:0] quo_r [m3i_pkg::DIV_NS][m3i_pkg::N_EL];
  logic [m3i_pkg::N_EL-1:0]  ovf_r [m3i_pkg::DIV_NS];
  logic [m3i_pkg::N_EL-1:0]  neg_r [m3i_pkg::DIV_NS];
  logic [m3i_pkg::DEN_W-1:0] d2_r  [m3i_pkg::DIV_NS];
  logic                      sing_r [m3i_pkg::DIV_NS];
  logic                      v_r    [m3i_pkg::DIV_NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < m3i_pkg::N_EL; l++) begin
        rem_r[0][l] <= {{(m3i_pkg::DEN_W-m3i_pkg::NUM_W+m3i_pkg::QUO_W){1'b0}},
                        in_data.num[l][m3i_pkg::NUM_W-1:m3i_pkg::QUO_W]};
        nlo_r[0][l] <= in_data.num[l][m3i_pkg::QUO_W-1:0];
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= {{(m3i_pkg::DEN_W-m3i_pkg::NUM_W+m3i_pkg::QUO_W){1'b0}},
                        in_data.num[l][m3i_pkg::NUM_W-1:m3i_pkg::QUO_W]} >= in_data.d2;
      end
      neg_r[0]  <= in_data.neg;
      d2_r[0]   <= in_data.d2;
      sing_r[0] <= in_data.singular;
    end
  end

  for (genvar s = 1; s < m3i_pkg::DIV_NS; s++) begin : g_stage
    logic [m3i_pkg::DEN_W:0]  trial [m3i_pkg::N_EL];
    logic [m3i_pkg::DEN_W:0]  diff  [m3i_pkg::N_EL];
    logic [m3i_pkg::N_EL-1:0] ge;

    always_comb begin
      for (int l = 0; l < m3i_pkg::N_EL; l++) begin
        trial[l] = {rem_r[s-1][l], nlo_r[s-1][l][m3i_pkg::QUO_W-s]};
        diff[l]  = trial[l] - {1'b0, d2_r[s-1]};
        ge[l]    = trial[l] >= {1'b0, d2_r[s-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < m3i_pkg::N_EL; l++) begin
          rem_r[s][l] <= ge[l] ? diff[l][m3i_pkg::DEN_W-1:0] : trial[l][m3i_pkg::DEN_W-1:0];
          nlo_r[s][l] <= nlo_r[s-1][l];
          quo_r[s][l] <= {quo_r[s-1][l][m3i_pkg::QUO_W-2:0], ge[l]};
        end
        ovf_r[s]  <= ovf_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        d2_r[s]   <= d2_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < m3i_pkg::N_EL; l++) begin
      out_data.quo[l] = quo_r[m3i_pkg::DIV_NS-1][l];
    end
    out_data.ovf      = ovf_r[m3i_pkg::DIV_NS-1];
    out_data.neg      = neg_r[m3i_pkg::DIV_NS-1];
    out_data.singular = sing_r[m3i_pkg::DIV_NS-1];
  end

  assign out_valid = v_r[m3i_pkg::DIV_NS-1];

endmodule

// ----- rtl/core/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// matrix3x3_inverse: one 3x3 Q16.16 matrix in, its saturated inverse out, per beat
// depends on m3i_pkg, m3i_cof, m3i_det, m3i_div

// Takes one matrix every cycle while the output is not stalled and returns its
// inverse. The path from input to output has 42 register stages, the first loaded
// as the beat enters the pipeline: the 33 stages of the restoring divider
// (one quotient bit each, nine lanes side by side) plus seven stages for the
// cofactors and determinant, an overflow check stage and the output register.
// A zero determinant gives the identity with singular set.
// Each element is rounded to nearest, ties away from zero, and saturated. A
// one-entry skid register at the input keeps in_stall registered; the block
// keeps accepting while a finished result waits on out_stall until the skid fills.

module matrix3x3_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  m3i_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output m3i_pkg::out_t out_data
);

  logic                en;
  logic                in_fire;
  logic                skid_v_r;
  m3i_pkg::in_t        skid_r;
  logic                pipe_v;
  m3i_pkg::in_t        pipe_d;
  logic                cof_v, det_v, div_v;
  m3i_pkg::cof_beat_t  cof_beat;
  m3i_pkg::div_beat_t  div_beat;
  m3i_pkg::quo_beat_t  quo_beat;
  logic [m3i_pkg::ELEM_W-1:0] res [m3i_pkg::N_EL];
  logic [m3i_pkg::ELEM_W-1:0] qneg [m3i_pkg::N_EL];
  m3i_pkg::out_t       out_nxt;
  m3i_pkg::out_t       out_r;
  logic                out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !skid_v_r;
  assign pipe_v   = skid_v_r || in_fire;
  assign pipe_d   = skid_v_r ? skid_r : in_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_r <= in_data;
    end
  end

  m3i_cof u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pipe_v),
    .in_data   (pipe_d),
    .out_valid (cof_v),
    .out_data  (cof_beat)
  );

  m3i_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cof_v),
    .in_data   (cof_beat),
    .out_valid (det_v),
    .out_data  (div_beat)
  );

  m3i_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (det_v),
    .in_data   (div_beat),
    .out_valid (div_v),
    .out_data  (quo_beat)
  );

  // apply sign, saturate, identity on singular
  always_comb begin
    for (int l = 0; l < m3i_pkg::N_EL; l++) begin
      qneg[l] = -quo_beat.quo[l][m3i_pkg::ELEM_W-1:0];
      if (quo_beat.singular) begin
        res[l] = m3i_pkg::IDENT[l];
      end else if (!quo_beat.neg[l]) begin
        res[l] = (quo_beat.ovf[l] || quo_beat.quo[l] > m3i_pkg::LIM_POS)
               ? m3i_pkg::SAT_POS : quo_beat.quo[l][m3i_pkg::ELEM_W-1:0];
      end else begin
        res[l] = (quo_beat.ovf[l] || quo_beat.quo[l] > m3i_pkg::LIM_NEG)
               ? m3i_pkg::SAT_NEG : qneg[l];
      end
    end
    out_nxt.inv00    = res[0];
    out_nxt.inv01    = res[1];
    out_nxt.inv02    = res[2];
    out_nxt.inv10    = res[3];
    out_nxt.inv11    = res[4];
    out_nxt.inv12    = res[5];
    out_nxt.inv20    = res[6];
    out_nxt.inv21    = res[7];
    out_nxt.inv22    = res[8];
    out_nxt.singular = quo_beat.singular;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_singular_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.inv00 == m3i_pkg::Q_ONE && out_data.inv11 == m3i_pkg::Q_ONE &&
      out_data.inv22 == m3i_pkg::Q_ONE && out_data.inv01 == '0 && out_data.inv12 == '0)
    else $error("singular beat without identity matrix");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(!en))
    else $error("skid register filled while pipeline advanced");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && en |=> !skid_v_r)
    else $error("skid register not drained on advance");
`endif

endmodule

// ----- bench/m3i_checker.sv -----
`timescale 1ns / 1ps
// m3i_checker: watches both channels of matrix3x3_inverse, predicts each inverse and compares
// depends on m3i_pkg

module m3i_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  m3i_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  m3i_pkg::out_t out_data,
  output int            n_fail,
  output int            n_pending,
  output int            n_matrices,
  output int            n_singular
);

  m3i_pkg::out_t inv_q[$];

  function automatic logic signed [31:0] round_div(logic signed [63:0] c,
                                                  logic signed [127:0] det);
    logic [127:0] dmag, cm, num, q;
    logic neg;
    dmag = det[127] ? -det : det;
    cm = c[63] ? -{{64{c[63]}}, c} : {64'd0, c};
    neg = c[63] ^ det[127];
    num = (cm << 33) + dmag;
    q = num / (dmag << 1);
    if (!neg) return (q > 128'h7fff_ffff) ? m3i_pkg::SAT_POS : q[31:0];
    if (q > 128'h8000_0000) return m3i_pkg::SAT_NEG;
    return -q[31:0];
  endfunction

  function automatic m3i_pkg::out_t inverse_of(m3i_pkg::in_t m);
    logic signed [63:0] a [9];
    logic signed [63:0] cof [9];
    logic signed [127:0] det;
    logic signed [31:0] r [9];
    m3i_pkg::out_t o;
    a = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[5] * a[6] - a[3] * a[8];
    cof[2] = a[3] * a[7] - a[4] * a[6];
    cof[3] = a[2] * a[7] - a[1] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[1] * a[6] - a[0] * a[7];
    cof[6] = a[1] * a[5] - a[2] * a[4];
    cof[7] = a[2] * a[3] - a[0] * a[5];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = 128'(a[0]) * 128'(cof[0]) + 128'(a[1]) * 128'(cof[1])
        + 128'(a[2]) * 128'(cof[2]);
    if (det == 0) begin
      o = {m3i_pkg::Q_ONE, 32'h0, 32'h0, 32'h0, m3i_pkg::Q_ONE, 32'h0, 32'h0, 32'h0,
           m3i_pkg::Q_ONE, 1'b1};
      return o;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i * 3 + j] = round_div(cof[j * 3 + i], det);
    o = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0};
    return o;
  endfunction

  always @(posedge clk) begin
    m3i_pkg::out_t want;
    if (!rst_n) begin
      n_fail <= 0;
      n_pending <= 0;
      n_matrices <= 0;
      n_singular <= 0;
    end else begin
      if (in_valid && !in_stall) inv_q.push_back(inverse_of(in_data));
      if (out_valid && !out_stall) begin
        n_matrices <= n_matrices + 1;
        if (out_data.singular) n_singular <= n_singular + 1;
        if (inv_q.size() == 0) begin
          if (n_fail < 10) $display("unexpected result beat %h", out_data);
          n_fail <= n_fail + 1;
        end else begin
          want = inv_q.pop_front();
          if (want !== out_data) begin
            if (n_fail < 10)
              $display("mismatch: expected %h actual %h", want, out_data);
            n_fail <= n_fail + 1;
          end
        end
      end
      n_pending <= inv_q.size();
    end
  end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// tb: drives random and directed matrices into matrix3x3_inverse under varying back-pressure
// depends on m3i_pkg, m3i_checker and the block

module tb;

  localparam int WATCHDOG = 20000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  m3i_pkg::in_t  in_data;
  m3i_pkg::out_t out_data;
  int   n_fail, n_pending, n_matrices, n_singular;
  int   idle_in, stall_out, quiet;
  bit   timed_out;

  matrix3x3_inverse u_dut (.*);

  m3i_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // random receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_out);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
  end

  function automatic m3i_pkg::elem_t rnd_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(131071)) - 65536;
      2: return $signed($urandom_range(32'h3ffffff)) - 32'sh2000000;
      3: return $signed($urandom_range(255)) - 128;
      default: begin
        case ($urandom_range(5))
          0: return m3i_pkg::SAT_NEG;
          1: return m3i_pkg::SAT_POS;
          2: return 0;
          3: return m3i_pkg::Q_ONE;
          4: return -m3i_pkg::Q_ONE;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic m3i_pkg::in_t rnd_matrix();
    m3i_pkg::in_t m;
    int k;
    k = $urandom_range(4);
    m = {rnd_elem(k), rnd_elem(k), rnd_elem(k), rnd_elem(k), rnd_elem(k),
         rnd_elem(k), rnd_elem(k), rnd_elem(k), rnd_elem(k)};
    case ($urandom_range(7))
      0: begin
        m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
      end
      1: begin
        m.a10 = 0; m.a11 = 0; m.a12 = 0;
      end
      2: begin
        m = '0;
        m.a00 = rnd_elem(1); m.a11 = rnd_elem(1); m.a22 = rnd_elem(1);
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send(m3i_pkg::in_t m);
    while (idle_in > 0 && $urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (n_pending != 0 && quiet < WATCHDOG) @(posedge clk);
  endtask

  initial begin
    m3i_pkg::in_t m;
    m3i_pkg::in_t dir [$];
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    idle_in = 0; stall_out = 0; quiet = 0; timed_out = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    fork
      begin
        m = '0; dir.push_back(m);
        m = '0; m.a00 = m3i_pkg::Q_ONE; m.a11 = m3i_pkg::Q_ONE; m.a22 = m3i_pkg::Q_ONE;
        dir.push_back(m);
        m.a00 = -m3i_pkg::Q_ONE; dir.push_back(m);
        m = '0; m.a00 = 1; m.a11 = 1; m.a22 = 1; dir.push_back(m);
        m = '0; m.a00 = m3i_pkg::SAT_POS; m.a11 = m3i_pkg::SAT_POS; m.a22 = m3i_pkg::SAT_POS;
        dir.push_back(m);
        m = '0; m.a00 = m3i_pkg::SAT_NEG; m.a11 = m3i_pkg::SAT_NEG; m.a22 = m3i_pkg::SAT_NEG;
        dir.push_back(m);
        m = {9{m3i_pkg::SAT_NEG}}; dir.push_back(m);
        m = {9{m3i_pkg::SAT_POS}}; dir.push_back(m);
        m = {m3i_pkg::SAT_NEG, m3i_pkg::SAT_POS, 32'h0, m3i_pkg::SAT_POS, m3i_pkg::SAT_NEG,
             m3i_pkg::SAT_POS, 32'h0, m3i_pkg::SAT_POS, m3i_pkg::SAT_NEG};
        dir.push_back(m);
        m = {32'h2_0000, 32'h0, 32'h0, 32'h0, 32'h2_0000, 32'h0, 32'h0, 32'h0, 32'h2_0000};
        dir.push_back(m);
        m = {32'h3_0000, 32'h0, 32'h0, 32'h0, 32'h3_0000, 32'h0, 32'h0, 32'h0, 32'h3_0000};
        dir.push_back(m);
        m = {32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1};
        dir.push_back(m);
        m = {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'h9};
        dir.push_back(m);
        m = {32'h0, m3i_pkg::Q_ONE, 32'h0, 32'h0, 32'h0, m3i_pkg::Q_ONE, m3i_pkg::Q_ONE,
             32'h0, 32'h0};
        dir.push_back(m);
        foreach (dir[i]) send(dir[i]);
        for (int ph = 0; ph < 5; ph++) begin
          drain();
          case (ph)
            0: begin idle_in = 0;  stall_out = 0;  end
            1: begin idle_in = 86; stall_out = 0;  end
            2: begin idle_in = 0;  stall_out = 86; end
            3: begin idle_in = 12; stall_out = 12; end
            default: begin idle_in = 0; stall_out = 0; end
          endcase
          repeat (250) send(rnd_matrix());
        end
        drain();
        stall_out = 0;
        repeat (60) @(posedge clk);
      end
      begin
        wait (quiet >= WATCHDOG);
        timed_out = 1;
      end
    join_any
    disable fork;
    $display("%0d result beats checked, %0d singular, over four back-pressure mixes",
             n_matrices, n_singular);
    if (timed_out || n_fail != 0 || n_pending != 0) begin
      $display("failures: %0d, outstanding: %0d", n_fail, n_pending);
      $display("matrix3x3_inverse verification failed");
    end else begin
      $display("matrix3x3_inverse verification clean");
    end
    $finish;
  end
endmodule
